/* design/mvpsp_pkg.sv */
// ----------------------------------------------------------------------------
// mvpsp_pkg
// Shared constants for the multi-voice PCM sample player.
// ----------------------------------------------------------------------------
`default_nettype none
package mvpsp_pkg;
   localparam int VOICE_COUNT   = 8;
   localparam int MEM_ADDR_BITS = 16;
   localparam int MEM_DEPTH     = 1 << MEM_ADDR_BITS;

   // request kinds
   localparam logic [1:0] REQ_REG_WRITE = 2'd0;
   localparam logic [1:0] REQ_MEM_WRITE = 2'd1;
   localparam logic [1:0] REQ_TICK      = 2'd2;

   // voice register offsets
   localparam logic [4:0] REG_START    = 5'h00;
   localparam logic [4:0] REG_LSTART   = 5'h04;
   localparam logic [4:0] REG_LEND     = 5'h08;
   localparam logic [4:0] REG_END      = 5'h0c;
   localparam logic [4:0] REG_STEP     = 5'h10;
   localparam logic [4:0] REG_VOL_L    = 5'h14;
   localparam logic [4:0] REG_VOL_R    = 5'h15;
   localparam logic [4:0] REG_CONTROL  = 5'h16;
   localparam logic [7:0] PLAY_MASK    = 8'h06;
endpackage
`default_nettype wire

/* design/multi_voice_pcm_sample_player_top.sv */
// ----------------------------------------------------------------------------
// multi_voice_pcm_sample_player_top
// Eight-voice 8-bit PCM player with stereo mixing.
// ----------------------------------------------------------------------------
// After reset the block clears all 256 bytes of the voice register RAM and is
// not ready meanwhile. A register write reads the old byte, then writes the
// new one; a memory write only writes. A tick walks the voices one after
// another through a byte-wide sequencer on the voice register RAM: an idle
// voice only has its control byte read; a playing one has its register bytes
// read, then a sample read, two mix steps, phase advance and compare, plus a
// stop step when it stops at its end. The single register file port is why
// the register bytes are read one by one. Results leave through an output
// register, so a new item is taken while a result waits; a tick then holds
// at its end until the register is free.
`default_nettype none
module multi_voice_pcm_sample_player_top
   import mvpsp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [1:0] req_type, [9:2] reg_address, [25:10] mem_address, [33:26] write_byte
   input  wire logic [39:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [14:0] left_sample, [29:15] right_sample, [37:30] active_voices
   output logic [39:0]      rsp_tdata
);
   localparam logic [4:0] S_IDLE   = 5'd0;
   localparam logic [4:0] S_REGRD  = 5'd1;   // wait for old register byte
   localparam logic [4:0] S_REGWR  = 5'd2;
   localparam logic [4:0] S_CLR    = 5'd3;   // reset clearing pass
   localparam logic [4:0] S_VCTL   = 5'd4;   // issue control read
   localparam logic [4:0] S_VCTLW  = 5'd5;
   localparam logic [4:0] S_RD     = 5'd6;   // byte read loop
   localparam logic [4:0] S_SMP    = 5'd7;   // form sample address
   localparam logic [4:0] S_SMPW   = 5'd8;
   localparam logic [4:0] S_MIXL   = 5'd9;
   localparam logic [4:0] S_MIXR   = 5'd10;
   localparam logic [4:0] S_ADV    = 5'd11;
   localparam logic [4:0] S_CMP    = 5'd12;
   localparam logic [4:0] S_STOP   = 5'd13;
   localparam logic [4:0] S_NEXT   = 5'd14;
   localparam logic [4:0] S_OUT    = 5'd15;
   localparam logic [4:0] S_OUTW   = 5'd16;

   localparam int VB = $clog2(VOICE_COUNT) > 0 ? $clog2(VOICE_COUNT) : 1;

   logic [4:0]  state_ff, state_in;
   logic [1:0]  kind_ff, kind_in;
   logic [7:0]  ra_ff, ra_in;
   logic [15:0] ma_ff, ma_in;
   logic [7:0]  wb_ff, wb_in;
   logic [7:0]  clr_ff, clr_in;
   logic [2:0]  voice_ff, voice_in;
   logic [4:0]  bidx_ff, bidx_in;     // register byte index under read
   logic        rpend_ff, rpend_in;   // a read is in flight
   logic [7:0]  ctl_ff, ctl_in;
   logic [23:0] st_ff, st_in, ls_ff, ls_in, le_ff, le_in, en_ff, en_in;
   logic [15:0] step_ff, step_in;
   logic signed [7:0] vl_ff, vl_in, vr_ff, vr_in;
   logic signed [7:0] smp_ff, smp_in;
   logic signed [19:0] suml_ff, suml_in, sumr_ff, sumr_in;
   logic [7:0]  act_ff, act_in;
   logic [24:0] pos_ff [VOICE_COUNT];
   logic [24:0] pos_in;
   logic [15:0] fr_ff [VOICE_COUNT];
   logic [15:0] fr_in;
   logic [VOICE_COUNT-1:0] lp_ff;
   logic        lp_in, vwr;
   logic [25:0] addr_ff, addr_in;     // start + position, shared adder result
   logic        key_on;
   logic        rsp_v_ff, rsp_v_in;
   logic [39:0] rsp_d_ff, rsp_d_in;

   // register RAM port
   logic        rr_we;
   logic [7:0]  rr_addr, rr_wd, rr_rd;
   // sample RAM port
   logic        sm_we;
   logic [MEM_ADDR_BITS-1:0] sm_addr;
   logic [7:0]  sm_rd;

   mvpsp_ram #(.WIDTH(8), .DEPTH(256)) u_regs (
      .clock(clock), .wr_en(rr_we), .addr(rr_addr), .wr_data(rr_wd), .rd_data(rr_rd));
   mvpsp_ram #(.WIDTH(8), .DEPTH(MEM_DEPTH)) u_smem (
      .clock(clock), .wr_en(sm_we), .addr(sm_addr), .wr_data(wb_ff), .rd_data(sm_rd));

   logic [VB-1:0] vidx;
   logic [VB-1:0] kvidx;
   logic [24:0]   sum25;
   logic [25:0]   cmp_a;
   logic [16:0]   frsum;
   logic          ge;
   logic signed [15:0] prod;
   assign vidx  = voice_ff[VB-1:0];
   assign kvidx = ra_ff[5+VB-1:5];
   assign frsum = {1'b0, fr_ff[vidx]} + {1'b0, step_ff};

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = rsp_d_ff;

   // sequencer
   always_comb begin
      state_in = state_ff; kind_in = kind_ff; ra_in = ra_ff; ma_in = ma_ff;
      wb_in = wb_ff; clr_in = clr_ff; voice_in = voice_ff; bidx_in = bidx_ff;
      rpend_in = 1'b0; ctl_in = ctl_ff; st_in = st_ff; ls_in = ls_ff;
      le_in = le_ff; en_in = en_ff; step_in = step_ff; vl_in = vl_ff;
      vr_in = vr_ff; smp_in = smp_ff; suml_in = suml_ff; sumr_in = sumr_ff;
      act_in = act_ff; addr_in = addr_ff; rsp_v_in = rsp_v_ff;
      rsp_d_in = rsp_d_ff;
      rr_we = 1'b0; rr_addr = ra_ff; rr_wd = wb_ff;
      sm_we = 1'b0; sm_addr = ma_ff[MEM_ADDR_BITS-1:0];
      pos_in = pos_ff[vidx]; fr_in = fr_ff[vidx]; lp_in = lp_ff[vidx]; vwr = 1'b0;
      key_on = 1'b0;
      prod = '0; sum25 = '0; cmp_a = '0; ge = 1'b0;
      if (rsp_v_ff && rsp_tready) begin
         rsp_v_in = 1'b0;
      end
      case (state_ff)
         S_CLR: begin
            rr_we = 1'b1; rr_addr = clr_ff; rr_wd = 8'h00;
            clr_in = clr_ff + 8'd1;
            if (clr_ff == 8'hff) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               kind_in = req_tdata[1:0]; ra_in = req_tdata[9:2];
               ma_in = req_tdata[25:10]; wb_in = req_tdata[33:26];
               case (req_tdata[1:0])
                  REQ_REG_WRITE: state_in = S_REGRD;
                  REQ_MEM_WRITE: state_in = S_REGWR;
                  REQ_TICK: begin
                     state_in = S_VCTL; voice_in = '0; suml_in = '0;
                     sumr_in = '0; act_in = '0;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_REGRD: begin
            // read old byte at ra (address held)
            state_in = S_REGWR;
         end
         S_REGWR: begin
            if (kind_ff == REQ_MEM_WRITE) begin
               sm_we = 1'b1;
            end else begin
               rr_we = 1'b1;
               if ({1'b0, ra_ff[7:5]} < 4'(VOICE_COUNT) && ra_ff[4:0] == REG_CONTROL &&
                   wb_ff != rr_rd && wb_ff != 8'h00) begin
                  key_on = 1'b1;
               end
            end
            state_in = S_IDLE;
         end
         S_VCTL: begin
            rr_addr = {voice_ff, REG_CONTROL};
            state_in = S_VCTLW;
         end
         S_VCTLW: begin
            rr_addr = {voice_ff, REG_CONTROL};
            ctl_in = rr_rd;
            if ((rr_rd & PLAY_MASK) == 8'h00) begin
               state_in = S_NEXT;
            end else begin
               bidx_in = '0; state_in = S_RD;
            end
         end
         S_RD: begin
            // one byte per cycle, data arrives in the next cycle
            rr_addr = {voice_ff, bidx_ff};
            rpend_in = 1'b1;
            if (rpend_ff) begin
               case (bidx_ff - 5'd1)
                  5'h00: st_in[7:0] = rr_rd;
                  5'h01: st_in[15:8] = rr_rd;
                  5'h02: st_in[23:16] = rr_rd;
                  5'h04: ls_in[7:0] = rr_rd;
                  5'h05: ls_in[15:8] = rr_rd;
                  5'h06: ls_in[23:16] = rr_rd;
                  5'h08: le_in[7:0] = rr_rd;
                  5'h09: le_in[15:8] = rr_rd;
                  5'h0a: le_in[23:16] = rr_rd;
                  5'h0c: en_in[7:0] = rr_rd;
                  5'h0d: en_in[15:8] = rr_rd;
                  5'h0e: en_in[23:16] = rr_rd;
                  5'h10: step_in[7:0] = rr_rd;
                  5'h11: step_in[15:8] = rr_rd;
                  5'h14: vl_in = rr_rd;
                  5'h15: vr_in = rr_rd;
                  default: ;
               endcase
            end
            bidx_in = bidx_ff + 5'd1;
            if (bidx_ff == REG_CONTROL) begin
               state_in = S_SMP;
            end
         end
         S_SMP: begin
            // shared adder: start + position
            sum25 = {1'b0, st_ff} + pos_ff[vidx];
            addr_in = {1'b0, sum25};
            state_in = S_SMPW;
         end
         S_SMPW: begin
            sm_addr = addr_ff[MEM_ADDR_BITS-1:0];
            state_in = S_MIXL;
         end
         S_MIXL: begin
            smp_in = sm_rd;
            prod = $signed(sm_rd) * vl_ff;
            suml_in = suml_ff + 20'(prod);
            state_in = S_MIXR;
         end
         S_MIXR: begin
            prod = smp_ff * vr_ff;
            sumr_in = sumr_ff + 20'(prod);
            state_in = S_ADV;
         end
         S_ADV: begin
            // advance phase, then form signed start + position for the compare
            sum25 = pos_ff[vidx] + 25'(frsum[16]);
            pos_in = sum25; fr_in = frsum[15:0]; vwr = 1'b1;
            addr_in = {sum25[24], sum25} + {2'b00, st_ff};
            state_in = S_CMP;
         end
         S_CMP: begin
            cmp_a = lp_ff[vidx] ? {2'b00, le_ff} : {2'b00, en_ff};
            ge = $signed(addr_ff) >= $signed(cmp_a);
            state_in = S_NEXT;
            if (ge) begin
               if (lp_ff[vidx] || ctl_ff[0]) begin
                  pos_in = {1'b0, ls_ff} - {1'b0, st_ff};
                  lp_in = 1'b1; vwr = 1'b1;
               end else begin
                  pos_in = '0; fr_in = '0; vwr = 1'b1;
                  state_in = S_STOP;
               end
            end
         end
         S_STOP: begin
            rr_we = 1'b1; rr_addr = {voice_ff, REG_CONTROL}; rr_wd = 8'h00;
            ctl_in = 8'h00;
            state_in = S_NEXT;
         end
         S_NEXT: begin
            if ((ctl_ff & PLAY_MASK) != 8'h00 && state_ff == S_NEXT) begin
               act_in[voice_ff] = 1'b1;
            end
            voice_in = voice_ff + 3'd1;
            ctl_in = 8'h00;
            if ({1'b0, voice_ff} == 4'(VOICE_COUNT - 1)) begin
               state_in = S_OUT;
            end else begin
               state_in = S_VCTL;
            end
         end
         S_OUT: begin
            state_in = S_OUTW;
         end
         S_OUTW: begin
            if (!rsp_v_ff) begin
               rsp_v_in = 1'b1;
               rsp_d_in = {2'b00, act_ff, 15'(sumr_ff >>> 4), 15'(suml_ff >>> 4)};
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR; clr_ff <= '0; rsp_v_ff <= 1'b0; rpend_ff <= 1'b0;
         lp_ff <= '0;
         for (int i = 0; i < VOICE_COUNT; i++) begin
            pos_ff[i] <= '0; fr_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in; clr_ff <= clr_in; rsp_v_ff <= rsp_v_in;
         rpend_ff <= rpend_in;
         if (key_on) begin
            pos_ff[kvidx] <= '0; fr_ff[kvidx] <= '0; lp_ff[kvidx] <= 1'b0;
         end else if (vwr) begin
            pos_ff[vidx] <= pos_in; fr_ff[vidx] <= fr_in; lp_ff[vidx] <= lp_in;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      kind_ff <= kind_in; ra_ff <= ra_in; ma_ff <= ma_in; wb_ff <= wb_in;
      voice_ff <= voice_in; bidx_ff <= bidx_in; ctl_ff <= ctl_in;
      st_ff <= st_in; ls_ff <= ls_in; le_ff <= le_in; en_ff <= en_in;
      step_ff <= step_in; vl_ff <= vl_in; vr_ff <= vr_in; smp_ff <= smp_in;
      suml_ff <= suml_in; sumr_ff <= sumr_in; act_ff <= act_in;
      addr_ff <= addr_in; rsp_d_ff <= rsp_d_in;
   end
endmodule
`default_nettype wire

/* design/mvpsp_ram.sv */
// ----------------------------------------------------------------------------
// mvpsp_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module mvpsp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   // read one entry per cycle, and write it too when wr_en is set
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule
`default_nettype wire
